// File: rtl/aab_pkg.sv
package aab_pkg;

    // Break point tables: five one-byte entries, entry 0 in the low byte.
    localparam int TABLE_W      = 40;
    localparam int TABLE_POINTS = TABLE_W / 8;
    localparam int NUM_POINTS   = 5;
    localparam int SMOOTH_DIV   = 8;

    // Divider widths: a 16-bit dividend and an 8-bit divisor.
    localparam int DVD_W = 16;
    localparam int DIV_W = 8;
    localparam int CNT_W = $clog2(DVD_W);

    // Manual level is percent * 255 / 100; the division by 100 is a
    // multiplication by a reciprocal and a shift.
    localparam logic [12:0] MAN_RECIP = 13'd5243;
    localparam int          MAN_SHIFT = 19;

    // Reset values.
    localparam logic [TABLE_W-1:0] LIGHT_TAB_RST = 40'h64140C0600;
    localparam logic [TABLE_W-1:0] LEVEL_TAB_RST = 40'hFFFF824601;
    localparam logic [7:0]         MANUAL_RST    = 8'd127;
    localparam logic [7:0]         GOAL_RST      = 8'd255;
    localparam logic [11:0]        LEVEL_RST     = 12'd4080;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_AUTO_ENABLE    = 2'd0,
        CFG_MANUAL_PERCENT = 2'd1,
        CFG_POINT_LIGHT    = 2'd2,
        CFG_POINT_LEVEL    = 2'd3
    } cfg_index_t;

    // Input item: mode 0 is a light sample, mode 1 a smoothing tick.
    typedef struct packed {
        logic       mode;
        logic [6:0] light_level;
    } sample_t;

    // Result item.
    typedef struct packed {
        logic [7:0] drive_level;
        logic [7:0] goal_level;
    } result_t;

    // One byte of a break point table; points past the table read as zero.
    function automatic logic [7:0] point_byte(input logic [TABLE_W-1:0] tab, input int idx);
        logic [7:0] b;
        b = '0;
        if (idx >= 0 && idx < TABLE_POINTS)
        begin
            b = tab[idx*8 +: 8];
        end
        return b;
    endfunction

endpackage

// File: rtl/ambient_auto_brightness_top.sv
// An item goes straight to S_FINISH when the map clamps, the segment has zero width, the tick
// finds no difference or manual mode is set; a moving tick passes S_DIV and S_APPLY first, an
// interpolated light sample S_MUL, S_DIV and S_APPLY. The result is registered in S_FINISH
// once the result register is free. One item at a time: the next is accepted the cycle after
// the result is registered; the bit-serial divider is shared by the map and the smoothing.
// Reset (rst_n, asynchronous, active low) restores the tables, auto mode and full brightness.
module ambient_auto_brightness_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  aab_pkg::sample_t              sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output aab_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  aab_pkg::cfg_index_t           cfg_index,
    input  logic [aab_pkg::TABLE_W-1:0]   cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_DIV    = 5'b00100,
        S_APPLY  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                         state_reg;
    logic                           auto_reg;
    logic [7:0]                     manual_reg;
    logic [aab_pkg::TABLE_W-1:0]    light_tab_reg;
    logic [aab_pkg::TABLE_W-1:0]    level_tab_reg;
    logic [7:0]                     goal_reg;
    logic [11:0]                    level_reg;
    logic                           op_tick_reg;
    logic                           neg_reg;
    logic [7:0]                     base_reg;
    logic [7:0]                     dy_reg;
    logic [7:0]                     dl_reg;
    logic [aab_pkg::DIV_W-1:0]      divisor_reg;
    logic [aab_pkg::DVD_W-1:0]      dvd_reg;
    logic [aab_pkg::DIV_W-1:0]      rem_reg;
    logic [aab_pkg::CNT_W-1:0]      cnt_reg;
    aab_pkg::result_t               result_reg;
    logic                           result_valid_reg;

    logic                           accept;
    logic                           cfg_write;

    // Map search results.
    logic [7:0]                     l8;
    logic                           map_direct;
    logic [7:0]                     map_value;
    logic                           seg_found;
    logic [7:0]                     seg_x0;
    logic [7:0]                     seg_y0;
    logic [7:0]                     seg_y1;
    logic [7:0]                     seg_w;

    // Tick difference.
    logic [12:0]                    diff;
    logic [11:0]                    diff_mag;

    // Divider step.
    logic [9:0]                     trial;
    logic                           fits;

    // Apply step.
    logic [11:0]                    step;

    // Manual level from the written percent.
    logic [6:0]                     pct;
    logic [14:0]                    pct_x255;
    logic [27:0]                    pct_scaled;
    logic [7:0]                     man_new;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign cfg_write    = cfg_valid && cfg_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Piecewise-linear map: clamp at the ends, else the first matching segment.
    always_comb
    begin
        logic [7:0] xa;
        logic [7:0] xb;
        logic [7:0] first_x;
        logic [7:0] last_x;
        l8        = {1'b0, sample.light_level};
        first_x   = aab_pkg::point_byte(light_tab_reg, 0);
        last_x    = aab_pkg::point_byte(light_tab_reg, aab_pkg::NUM_POINTS - 1);
        seg_found = 1'b0;
        seg_x0    = '0;
        seg_y0    = '0;
        seg_y1    = '0;
        seg_w     = '0;
        for (int i = 0; i < aab_pkg::NUM_POINTS - 1; i++)
        begin
            xa = aab_pkg::point_byte(light_tab_reg, i);
            xb = aab_pkg::point_byte(light_tab_reg, i + 1);
            if (!seg_found && l8 >= xa && l8 <= xb)
            begin
                seg_found = 1'b1;
                seg_x0    = xa;
                seg_y0    = aab_pkg::point_byte(level_tab_reg, i);
                seg_y1    = aab_pkg::point_byte(level_tab_reg, i + 1);
                seg_w     = xb - xa;
            end
        end
        map_direct = 1'b1;
        if (l8 <= first_x)
        begin
            map_value = aab_pkg::point_byte(level_tab_reg, 0);
        end
        else if (l8 >= last_x || !seg_found)
        begin
            map_value = aab_pkg::point_byte(level_tab_reg, aab_pkg::NUM_POINTS - 1);
        end
        else if (seg_w == 8'd0)
        begin
            map_value = seg_y0;
        end
        else
        begin
            map_value  = seg_y0;
            map_direct = 1'b0;
        end
    end

    // Signed distance from the current level to the goal, in sixteenths.
    assign diff     = {1'b0, goal_reg, 4'b0000} - {1'b0, level_reg};
    assign diff_mag = diff[12] ? 12'(-diff) : diff[11:0];

    // Restoring division, one quotient bit per cycle.
    assign trial = {1'b0, rem_reg, dvd_reg[aab_pkg::DVD_W-1]} - {2'b00, divisor_reg};
    assign fits  = !trial[9];

    // Smoothing step is at least one unit.
    assign step = (dvd_reg[11:0] == 12'd0) ? 12'd1 : dvd_reg[11:0];

    // Clamp the written percent and scale it to a brightness level.
    always_comb
    begin
        pct = cfg_data[6:0];
        if (pct == 7'd0)
        begin
            pct = 7'd1;
        end
        else if (pct > 7'd100)
        begin
            pct = 7'd100;
        end
        pct_x255   = {pct, 8'b0} - {8'b0, pct};
        pct_scaled = {13'b0, pct_x255} * {15'b0, aab_pkg::MAN_RECIP};
        man_new    = pct_scaled[aab_pkg::MAN_SHIFT +: 8];
        if (man_new == 8'd0)
        begin
            man_new = 8'd1;
        end
    end

    // Sequencer, datapath and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            auto_reg         <= 1'b1;
            manual_reg       <= aab_pkg::MANUAL_RST;
            light_tab_reg    <= aab_pkg::LIGHT_TAB_RST;
            level_tab_reg    <= aab_pkg::LEVEL_TAB_RST;
            goal_reg         <= aab_pkg::GOAL_RST;
            level_reg        <= aab_pkg::LEVEL_RST;
            result_valid_reg <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            // The result register empties when its item is taken and no new item loads.
            if (result_valid_reg && !result_stall && state_reg != S_FINISH)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!auto_reg)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else if (sample.mode)
                        begin
                            op_tick_reg <= 1'b1;
                            neg_reg     <= diff[12];
                            dvd_reg     <= {{(aab_pkg::DVD_W-12){1'b0}}, diff_mag};
                            divisor_reg <= aab_pkg::DIV_W'(aab_pkg::SMOOTH_DIV);
                            rem_reg     <= '0;
                            cnt_reg     <= aab_pkg::CNT_W'(aab_pkg::DVD_W - 1);
                            state_reg   <= (diff == 13'd0) ? S_FINISH : S_DIV;
                        end
                        else if (map_direct)
                        begin
                            goal_reg  <= map_value;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            op_tick_reg <= 1'b0;
                            neg_reg     <= (seg_y1 < seg_y0);
                            dy_reg      <= (seg_y1 < seg_y0) ? (seg_y0 - seg_y1)
                                                             : (seg_y1 - seg_y0);
                            dl_reg      <= l8 - seg_x0;
                            base_reg    <= seg_y0;
                            divisor_reg <= seg_w;
                            state_reg   <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    dvd_reg   <= {8'b0, dy_reg} * {8'b0, dl_reg};
                    rem_reg   <= '0;
                    cnt_reg   <= aab_pkg::CNT_W'(aab_pkg::DVD_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= fits ? trial[7:0]
                                    : {rem_reg[aab_pkg::DIV_W-2:0], dvd_reg[aab_pkg::DVD_W-1]};
                    dvd_reg <= {dvd_reg[aab_pkg::DVD_W-2:0], fits};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_APPLY;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_APPLY:
                begin
                    if (op_tick_reg)
                    begin
                        level_reg <= neg_reg ? (level_reg - step) : (level_reg + step);
                    end
                    else
                    begin
                        goal_reg <= neg_reg ? (base_reg - dvd_reg[7:0])
                                            : (base_reg + dvd_reg[7:0]);
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // The user must write configuration only while the block is idle; the block does not enforce it.
            if (cfg_write)
            begin
                case (cfg_index)
                    aab_pkg::CFG_AUTO_ENABLE:
                    begin
                        auto_reg <= cfg_data[0];
                        if (!cfg_data[0])
                        begin
                            goal_reg  <= manual_reg;
                            level_reg <= {manual_reg, 4'b0000};
                        end
                    end
                    aab_pkg::CFG_MANUAL_PERCENT:
                    begin
                        manual_reg <= man_new;
                        if (!auto_reg)
                        begin
                            goal_reg  <= man_new;
                            level_reg <= {man_new, 4'b0000};
                        end
                    end
                    aab_pkg::CFG_POINT_LIGHT:
                    begin
                        light_tab_reg <= cfg_data;
                    end
                    aab_pkg::CFG_POINT_LEVEL:
                    begin
                        level_tab_reg <= cfg_data;
                    end
                    default:
                    begin
                        auto_reg <= auto_reg;
                    end
                endcase
            end
        end
    end

    // Result payload, loaded as the item finishes.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && (!result_valid_reg || !result_stall))
        begin
            result_reg.drive_level <= level_reg[11:4];
            result_reg.goal_level  <= goal_reg;
        end
    end

endmodule

// File: test/tb_ambient_auto_brightness_top.sv
`timescale 1ns / 1ps

module tb_ambient_auto_brightness_top;

    localparam int   CLK_HALF      = 5;
    localparam int   PHASES        = 8;
    localparam int   PHASE_ITEMS   = 50;
    localparam int   HOLD_CYCLES   = 80;
    localparam int   SETTLE_CYCLES = 25;
    localparam logic MODE_LIGHT    = 1'b0;
    localparam logic MODE_TICK     = 1'b1;

    // One row of the directed script: a register write or an item.
    typedef struct {
        bit                          is_write;
        aab_pkg::cfg_index_t         index;
        logic [aab_pkg::TABLE_W-1:0] data;
        aab_pkg::sample_t            item;
        bit                          typed;
        aab_pkg::result_t            want;
    } script_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        sample_valid;
    logic                        sample_stall;
    aab_pkg::sample_t            sample;
    logic                        result_valid;
    logic                        result_stall;
    aab_pkg::result_t            result;
    logic                        cfg_valid;
    logic                        cfg_ready;
    aab_pkg::cfg_index_t         cfg_index;
    logic [aab_pkg::TABLE_W-1:0] cfg_data;

    // Tracked copy of the block's registers and state.
    logic                        track_auto;
    logic [6:0]                  track_percent;
    logic [aab_pkg::TABLE_W-1:0] track_light_tab;
    logic [aab_pkg::TABLE_W-1:0] track_level_tab;
    logic [7:0]                  track_goal;
    logic [11:0]                 track_level_fx;

    aab_pkg::result_t            brightness_q[$];
    aab_pkg::result_t            oldest;
    script_row_t                 script_q[$];
    int                          error_count;
    bit                          idle_enable;
    bit                          hold_request;
    int                          hold_left;
    int                          rx_gap_left;

    ambient_auto_brightness_top u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Watchdog for a block that hangs or drops results.
    initial
    begin
        #3_000_000;
        $display("** ambient_auto_brightness_top: FAILED **");
        $finish;
    end

    // Map a light value through the break point tables.
    function automatic logic [7:0] map_light(input logic [6:0] light);
        int         l;
        int         x0;
        int         x1;
        int         y0;
        int         y1;
        logic [7:0] lvl;
        l = light;
        if (l <= track_light_tab[7:0])
        begin
            return track_level_tab[7:0];
        end
        if (l >= track_light_tab[aab_pkg::TABLE_W-1 -: 8])
        begin
            return track_level_tab[aab_pkg::TABLE_W-1 -: 8];
        end
        for (int i = 0; i < aab_pkg::NUM_POINTS - 1; i++)
        begin
            x0 = track_light_tab[i*8 +: 8];
            x1 = track_light_tab[(i+1)*8 +: 8];
            if (l >= x0 && l <= x1)
            begin
                y0 = track_level_tab[i*8 +: 8];
                y1 = track_level_tab[(i+1)*8 +: 8];
                // A segment of zero width takes its start level.
                if (x1 == x0)
                begin
                    lvl = 8'(y0);
                end
                else
                begin
                    lvl = 8'(y0 + ((y1 - y0) * (l - x0)) / (x1 - x0));
                end
                return lvl;
            end
        end
        return track_level_tab[aab_pkg::TABLE_W-1 -: 8];
    endfunction

    // Move the fixed-point level one step toward the goal.
    function automatic void smooth_toward_goal();
        int target;
        int cur;
        int diff;
        int stp;
        target = {track_goal, 4'b0000};
        cur    = track_level_fx;
        diff   = target - cur;
        if (diff > 0)
        begin
            stp = diff / aab_pkg::SMOOTH_DIV;
            if (stp < 1)
            begin
                stp = 1;
            end
            cur = cur + stp;
            if (cur > target)
            begin
                cur = target;
            end
        end
        else if (diff < 0)
        begin
            stp = (-diff) / aab_pkg::SMOOTH_DIV;
            if (stp < 1)
            begin
                stp = 1;
            end
            cur = cur - stp;
            if (cur < target)
            begin
                cur = target;
            end
        end
        track_level_fx = cur[11:0];
    endfunction

    // Load goal and level with the manual brightness at once.
    function automatic void load_manual();
        int lvl;
        lvl = track_percent * 255 / 100;
        if (lvl < 1)
        begin
            lvl = 1;
        end
        track_goal     = lvl[7:0];
        track_level_fx = {track_goal, 4'b0000};
    endfunction

    // Advance the tracked state by one item and return its result.
    function automatic aab_pkg::result_t predict_brightness(input aab_pkg::sample_t s);
        aab_pkg::result_t r;
        if (track_auto)
        begin
            if (s.mode == MODE_LIGHT)
            begin
                track_goal = map_light(s.light_level);
            end
            else
            begin
                smooth_toward_goal();
            end
        end
        r.drive_level = track_level_fx[11:4];
        r.goal_level  = track_goal;
        return r;
    endfunction

    // Apply a register write to the tracked state.
    function automatic void track_register(input aab_pkg::cfg_index_t idx,
                                           input logic [aab_pkg::TABLE_W-1:0] data);
        logic [6:0] pct;
        case (idx)
            aab_pkg::CFG_AUTO_ENABLE:
            begin
                track_auto = data[0];
                if (!track_auto)
                begin
                    load_manual();
                end
            end
            aab_pkg::CFG_MANUAL_PERCENT:
            begin
                pct = data[6:0];
                if (pct < 7'd1)
                begin
                    pct = 7'd1;
                end
                if (pct > 7'd100)
                begin
                    pct = 7'd100;
                end
                track_percent = pct;
                if (!track_auto)
                begin
                    load_manual();
                end
            end
            aab_pkg::CFG_POINT_LIGHT:
            begin
                track_light_tab = data;
            end
            default:
            begin
                track_level_tab = data;
            end
        endcase
    endfunction

    function automatic void add_write(input aab_pkg::cfg_index_t idx,
                                      input logic [aab_pkg::TABLE_W-1:0] data);
        script_row_t row;
        row          = '{index: aab_pkg::CFG_AUTO_ENABLE, default: '0};
        row.is_write = 1'b1;
        row.index    = idx;
        row.data     = data;
        script_q.push_back(row);
    endfunction

    function automatic void add_item(input logic mode, input logic [6:0] light, input bit typed,
                                     input logic [7:0] drive, input logic [7:0] goal);
        script_row_t row;
        row                  = '{index: aab_pkg::CFG_AUTO_ENABLE, default: '0};
        row.item.mode        = mode;
        row.item.light_level = light;
        row.typed            = typed;
        row.want.drive_level = drive;
        row.want.goal_level  = goal;
        script_q.push_back(row);
    endfunction

    // Directed script: reset values, clamps, manual mode and odd tables.
    function automatic void build_script();
        // Defaults after reset: level 255, points at 0 and 100 clamp.
        add_item(MODE_TICK,  7'd0,   1'b1, 8'd255, 8'd255);
        add_item(MODE_LIGHT, 7'd0,   1'b1, 8'd255, 8'd1);
        add_item(MODE_LIGHT, 7'd100, 1'b1, 8'd255, 8'd255);
        add_item(MODE_LIGHT, 7'd127, 1'b1, 8'd255, 8'd255);
        add_item(MODE_LIGHT, 7'd3,   1'b0, 8'd0, 8'd0);
        add_item(MODE_TICK,  7'd127, 1'b0, 8'd0, 8'd0);
        add_item(MODE_TICK,  7'd0,   1'b0, 8'd0, 8'd0);
        add_item(MODE_LIGHT, 7'd6,   1'b0, 8'd0, 8'd0);
        add_item(MODE_LIGHT, 7'd16,  1'b0, 8'd0, 8'd0);
        add_item(MODE_LIGHT, 7'd60,  1'b0, 8'd0, 8'd0);
        // Manual mode: the level jumps to percent * 255 / 100 and items change nothing.
        add_write(aab_pkg::CFG_AUTO_ENABLE, 40'hFF_FFFF_FFFE);
        add_item(MODE_LIGHT, 7'd0,   1'b1, 8'd127, 8'd127);
        add_item(MODE_TICK,  7'd55,  1'b1, 8'd127, 8'd127);
        add_write(aab_pkg::CFG_MANUAL_PERCENT, 40'd0);
        add_item(MODE_TICK,  7'd0,   1'b1, 8'd2, 8'd2);
        add_write(aab_pkg::CFG_MANUAL_PERCENT, 40'hA5_0000_007F);
        add_item(MODE_LIGHT, 7'd50,  1'b1, 8'd255, 8'd255);
        add_write(aab_pkg::CFG_MANUAL_PERCENT, 40'd37);
        add_item(MODE_TICK,  7'd1,   1'b0, 8'd0, 8'd0);
        add_write(aab_pkg::CFG_AUTO_ENABLE, 40'd1);
        add_item(MODE_TICK,  7'd0,   1'b0, 8'd0, 8'd0);
        // Repeated break points and descending levels.
        add_write(aab_pkg::CFG_POINT_LIGHT, 40'h64_3232_3200);
        add_write(aab_pkg::CFG_POINT_LEVEL, 40'h00_3264_C8FF);
        add_item(MODE_LIGHT, 7'd50,  1'b0, 8'd0, 8'd0);
        add_item(MODE_LIGHT, 7'd25,  1'b0, 8'd0, 8'd0);
        add_item(MODE_LIGHT, 7'd75,  1'b0, 8'd0, 8'd0);
        add_item(MODE_TICK,  7'd0,   1'b0, 8'd0, 8'd0);
        add_item(MODE_TICK,  7'd0,   1'b0, 8'd0, 8'd0);
        // All points at zero, all levels at full scale.
        add_write(aab_pkg::CFG_POINT_LIGHT, 40'h00_0000_0000);
        add_write(aab_pkg::CFG_POINT_LEVEL, 40'hFF_FFFF_FFFF);
        add_item(MODE_LIGHT, 7'd0,   1'b0, 8'd0, 8'd0);
        // Points out of order.
        add_write(aab_pkg::CFG_POINT_LIGHT, 40'h5A_0A50_1432);
        add_write(aab_pkg::CFG_POINT_LEVEL, 40'h80_40C0_1020);
        add_item(MODE_LIGHT, 7'd60,  1'b0, 8'd0, 8'd0);
        add_item(MODE_LIGHT, 7'd85,  1'b0, 8'd0, 8'd0);
        add_item(MODE_LIGHT, 7'd30,  1'b0, 8'd0, 8'd0);
        // All points at full scale, all levels at zero.
        add_write(aab_pkg::CFG_POINT_LIGHT, 40'hFF_FFFF_FFFF);
        add_write(aab_pkg::CFG_POINT_LEVEL, 40'h00_0000_0000);
        add_item(MODE_LIGHT, 7'd127, 1'b0, 8'd0, 8'd0);
    endfunction

    // Random break points, mostly ascending, sometimes repeated or shuffled.
    function automatic logic [aab_pkg::TABLE_W-1:0] random_light_points();
        logic [7:0]                  pt[aab_pkg::NUM_POINTS];
        logic [7:0]                  tmp;
        logic [aab_pkg::TABLE_W-1:0] tab;
        int                          pick;
        pick = $urandom_range(0, 9);
        for (int i = 0; i < aab_pkg::NUM_POINTS; i++)
        begin
            pt[i] = (pick < 8) ? 8'($urandom_range(0, 110)) : 8'($urandom_range(0, 255));
        end
        if (pick < 2)
        begin
            pt[2] = pt[1];
        end
        if (pick < 8)
        begin
            for (int i = 0; i < aab_pkg::NUM_POINTS - 1; i++)
            begin
                for (int j = 0; j < aab_pkg::NUM_POINTS - 1 - i; j++)
                begin
                    if (pt[j] > pt[j+1])
                    begin
                        tmp     = pt[j];
                        pt[j]   = pt[j+1];
                        pt[j+1] = tmp;
                    end
                end
            end
        end
        for (int i = 0; i < aab_pkg::NUM_POINTS; i++)
        begin
            tab[i*8 +: 8] = pt[i];
        end
        return tab;
    endfunction

    // Random item: ticks outnumber samples so the level keeps moving.
    function automatic aab_pkg::sample_t random_sample();
        aab_pkg::sample_t s;
        s.mode        = ($urandom_range(0, 9) < 6) ? MODE_TICK : MODE_LIGHT;
        s.light_level = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                     : 7'($urandom_range(0, 100));
        return s;
    endfunction

    // Write one register and track its effect.
    task automatic write_register(input aab_pkg::cfg_index_t idx,
                                  input logic [aab_pkg::TABLE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        track_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one item, with an optional gap before it, and record its result.
    task automatic send_sample(input aab_pkg::sample_t s, input bit typed,
                               input aab_pkg::result_t want);
        aab_pkg::result_t predicted;
        int               gap;
        @(negedge clk);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            sample_valid <= 1'b0;
            sample       <= 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        predicted = predict_brightness(s);
        brightness_q.push_back(typed ? want : predicted);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        sample_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (brightness_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Pick and write the settings of one random phase.
    task automatic configure_phase(input int p);
        logic                        auto_bit;
        logic [6:0]                  pct;
        logic [aab_pkg::TABLE_W-1:0] light_tab;
        logic [aab_pkg::TABLE_W-1:0] level_tab;
        logic [aab_pkg::TABLE_W-1:0] junk;
        auto_bit  = ($urandom_range(0, 4) != 0);
        pct       = 7'($urandom_range(0, 127));
        light_tab = random_light_points();
        level_tab = aab_pkg::TABLE_W'({$urandom, $urandom});
        junk      = ($urandom_range(0, 1) == 0) ? '0
                                                : aab_pkg::TABLE_W'({$urandom, $urandom});
        case (p)
            1:
            begin
                auto_bit = 1'b0;
                pct      = 7'd1;
            end
            2:
            begin
                auto_bit = 1'b0;
                pct      = 7'd100;
            end
            3:
            begin
                auto_bit  = 1'b1;
                level_tab = '0;
            end
            4:
            begin
                auto_bit  = 1'b1;
                level_tab = '1;
            end
            default:
            begin
            end
        endcase
        // The mode is written last so that it acts on the new percent.
        write_register(aab_pkg::CFG_MANUAL_PERCENT, {junk[aab_pkg::TABLE_W-1:7], pct});
        write_register(aab_pkg::CFG_POINT_LIGHT, light_tab);
        write_register(aab_pkg::CFG_POINT_LEVEL, level_tab);
        write_register(aab_pkg::CFG_AUTO_ENABLE, {junk[aab_pkg::TABLE_W-1:1], auto_bit});
    endtask

    // Result side stall: random bursts, plus one long hold on request.
    initial
    begin
        result_stall = 1'b0;
        hold_left    = 0;
        rx_gap_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left    = hold_left - 1;
                result_stall <= 1'b1;
            end
            else if (rx_gap_left > 0)
            begin
                rx_gap_left  = rx_gap_left - 1;
                result_stall <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 3) == 0)
            begin
                rx_gap_left  = $urandom_range(1, 6) - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result item with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (brightness_q.size() == 0)
            begin
                $display("%0t: unexpected result, drive_level %0d goal_level %0d",
                         $time, result.drive_level, result.goal_level);
                error_count = error_count + 1;
            end
            else
            begin
                oldest = brightness_q.pop_front();
                if (result.drive_level !== oldest.drive_level)
                begin
                    $display("%0t: drive_level expected %0d, actual %0d",
                             $time, oldest.drive_level, result.drive_level);
                    error_count = error_count + 1;
                end
                if (result.goal_level !== oldest.goal_level)
                begin
                    $display("%0t: goal_level expected %0d, actual %0d",
                             $time, oldest.goal_level, result.goal_level);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Main sequence: reset, directed script, then random phases.
    initial
    begin
        error_count     = 0;
        idle_enable     = 1'b1;
        hold_request    = 1'b0;
        sample_valid    = 1'b0;
        sample          = '0;
        cfg_valid       = 1'b0;
        cfg_index       = aab_pkg::CFG_AUTO_ENABLE;
        cfg_data        = '0;
        track_auto      = 1'b1;
        track_percent   = 7'd50;
        track_light_tab = 40'h64_140C_0600;
        track_level_tab = 40'hFF_FF82_4601;
        track_goal      = 8'd255;
        track_level_fx  = 12'd4080;
        rst_n           = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        build_script();
        foreach (script_q[k])
        begin
            if (script_q[k].is_write)
            begin
                stop_sending();
                wait_drained();
                write_register(script_q[k].index, script_q[k].data);
            end
            else
            begin
                send_sample(script_q[k].item, script_q[k].typed, script_q[k].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            // The final phase runs without idling on either side.
            idle_enable = (p != PHASES - 1);
            stop_sending();
            wait_drained();
            configure_phase(p);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 4 && n == 10)
                begin
                    hold_request = 1'b1;
                end
                if (p == 5 && n == 25)
                begin
                    stop_sending();
                    wait_drained();
                end
                send_sample(random_sample(), 1'b0, '0);
            end
        end

        stop_sending();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("** ambient_auto_brightness_top: PASSED **");
        end
        else
        begin
            $display("** ambient_auto_brightness_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/aab_pkg.sv
rtl/ambient_auto_brightness_top.sv
test/tb_ambient_auto_brightness_top.sv
